[design/assert_macros.svh]
// Assertion macros used by the checker file of this block.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every clock edge outside reset; expects clk and rst_n in scope.
`define CHK_ASSERT(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Check that a condition implies another one on the next clock edge.
`define CHK_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[design/dcpk_pkg.sv]
// Types, constants and decode functions for the digital clock with pause key.
`timescale 1ns / 1ps

package dcpk_pkg;

    localparam int SCAN_DIGITS = 8;
    localparam int SCAN_W      = $clog2(SCAN_DIGITS);
    localparam int CFG_IDX_W   = 4;
    localparam int CFG_DATA_W  = 16;
    localparam int TICK_W      = 16;
    localparam int HOUR_W      = 5;
    localparam int MIN_W       = 6;
    localparam int SEC_W       = 6;
    localparam int SEG_W       = 7;
    localparam int DEB_W       = 8;

    localparam logic [TICK_W-1:0] TPS_RESET        = 16'd1000;
    localparam logic [HOUR_W-1:0] ALARM_HOUR_RESET = 5'd0;
    localparam logic [MIN_W-1:0]  ALARM_MIN_RESET  = 6'd0;
    localparam logic [SEC_W-1:0]  ALARM_SEC_RESET  = 6'd30;

    localparam logic [SEC_W-1:0]  SEC_LAST  = 6'd59;
    localparam logic [MIN_W-1:0]  MIN_LAST  = 6'd59;
    localparam logic [HOUR_W-1:0] HOUR_LAST = 5'd23;

    localparam logic [SEG_W-1:0]  SEG_DASH = 7'h40;

    // Configuration register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        REG_TICKS_PER_SECOND = 4'd0,
        REG_ALARM_HOUR       = 4'd1,
        REG_ALARM_MINUTE     = 4'd2,
        REG_ALARM_SECOND     = 4'd3
    } cfg_reg_t;

    // Display digit positions, left to right
    localparam logic [SCAN_W-1:0] DIG_HOUR_TENS  = 3'd0;
    localparam logic [SCAN_W-1:0] DIG_HOUR_UNITS = 3'd1;
    localparam logic [SCAN_W-1:0] DIG_DASH_HM    = 3'd2;
    localparam logic [SCAN_W-1:0] DIG_MIN_TENS   = 3'd3;
    localparam logic [SCAN_W-1:0] DIG_MIN_UNITS  = 3'd4;
    localparam logic [SCAN_W-1:0] DIG_DASH_MS    = 3'd5;
    localparam logic [SCAN_W-1:0] DIG_SEC_TENS   = 3'd6;
    localparam logic [SCAN_W-1:0] DIG_SEC_UNITS  = 3'd7;

    typedef struct packed {
        logic [SCAN_W-1:0] scan_digit;
        logic [SEG_W-1:0]  scan_segments;
        logic [HOUR_W-1:0] hours;
        logic [MIN_W-1:0]  minutes;
        logic [SEC_W-1:0]  seconds;
        logic              running;
        logic              alarm_flag;
    } result_t;

    typedef struct packed {
        logic [2:0] tens;
        logic [3:0] units;
    } bcd2_t;

    // Split a value below 60 into decimal digits
    function automatic bcd2_t bcd_split(input logic [5:0] v);
        bcd2_t r;
        if (v >= 6'd50)
        begin
            r.tens  = 3'd5;
            r.units = 4'(v - 6'd50);
        end
        else if (v >= 6'd40)
        begin
            r.tens  = 3'd4;
            r.units = 4'(v - 6'd40);
        end
        else if (v >= 6'd30)
        begin
            r.tens  = 3'd3;
            r.units = 4'(v - 6'd30);
        end
        else if (v >= 6'd20)
        begin
            r.tens  = 3'd2;
            r.units = 4'(v - 6'd20);
        end
        else if (v >= 6'd10)
        begin
            r.tens  = 3'd1;
            r.units = 4'(v - 6'd10);
        end
        else
        begin
            r.tens  = 3'd0;
            r.units = v[3:0];
        end
        return r;
    endfunction

    // Seven-segment code, gfedcba
    function automatic logic [SEG_W-1:0] seg_code(input logic [3:0] d);
        logic [SEG_W-1:0] s;
        unique case (d)
            4'd0:    s = 7'h3f;
            4'd1:    s = 7'h06;
            4'd2:    s = 7'h5b;
            4'd3:    s = 7'h4f;
            4'd4:    s = 7'h66;
            4'd5:    s = 7'h6d;
            4'd6:    s = 7'h7d;
            4'd7:    s = 7'h07;
            4'd8:    s = 7'h7f;
            4'd9:    s = 7'h6f;
            default: s = 7'h3f;
        endcase
        return s;
    endfunction

endpackage

[design/digital_clock_with_pause_key_unit.sv]
// Top level of the digital clock with pause key and scanned seven-segment output.
`timescale 1ns / 1ps

// Each accepted request is one tick carrying a raw key sample; it yields exactly one
// result: the scanned digit and its segment code, the time after the tick, the running
// state and the sticky alarm flag. While in_stall is low a new tick can be taken every
// clock cycle, since the whole tick update (debounce, tick count, time advance, press
// toggle, digit decode) is one pass of combinational logic into the state and result
// registers. A two-entry output buffer (result register plus skid register) lets the
// input keep flowing while a result waits; in_stall rises only when both entries are
// full. Configuration writes are always ready and take effect on the next tick.
module digital_clock_with_pause_key_unit
    import dcpk_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    output logic                  in_stall,
    input  logic                  key_sample,
    output logic                  out_valid,
    input  logic                  out_stall,
    output logic [SCAN_W-1:0]     scan_digit,
    output logic [SEG_W-1:0]      scan_segments,
    output logic [HOUR_W-1:0]     hours,
    output logic [MIN_W-1:0]      minutes,
    output logic [SEC_W-1:0]      seconds,
    output logic                  running,
    output logic                  alarm_flag,
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data
);

    // Configuration registers
    logic [TICK_W-1:0] tps_reg;
    logic [HOUR_W-1:0] alarm_hour_reg;
    logic [MIN_W-1:0]  alarm_min_reg;
    logic [SEC_W-1:0]  alarm_sec_reg;

    // Clock state
    logic [DEB_W-1:0]  debounce_shift_reg, debounce_shift_next;
    logic              key_level_reg, key_level_next;
    logic              key_level_prev_reg;
    logic              run_flag_reg, run_flag_next;
    logic [TICK_W-1:0] tick_count_reg, tick_count_next;
    logic [SEC_W-1:0]  second_count_reg, second_count_next;
    logic [MIN_W-1:0]  minute_count_reg, minute_count_next;
    logic [HOUR_W-1:0] hour_count_reg, hour_count_next;
    logic              alarm_latch_reg, alarm_latch_next;
    logic [SCAN_W-1:0] scan_index_reg, scan_index_next;

    // Output buffer
    result_t           out_reg, skid_reg, result_next;
    logic              out_valid_reg, skid_valid_reg;

    logic              in_fire, out_fire;
    logic [TICK_W-1:0] tick_inc;
    logic              sec_tick;
    logic              press;
    logic [MIN_W-1:0]  digit_value;
    bcd2_t             digit_bcd;
    logic              digit_is_tens;

    assign cfg_ready = 1'b1;
    assign in_stall  = skid_valid_reg;
    assign in_fire   = in_valid && !skid_valid_reg;
    assign out_fire  = out_valid_reg && !out_stall;

    // Take configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tps_reg        <= TPS_RESET;
            alarm_hour_reg <= ALARM_HOUR_RESET;
            alarm_min_reg  <= ALARM_MIN_RESET;
            alarm_sec_reg  <= ALARM_SEC_RESET;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                REG_TICKS_PER_SECOND: tps_reg        <= cfg_data;
                REG_ALARM_HOUR:       alarm_hour_reg <= cfg_data[HOUR_W-1:0];
                REG_ALARM_MINUTE:     alarm_min_reg  <= cfg_data[MIN_W-1:0];
                REG_ALARM_SECOND:     alarm_sec_reg  <= cfg_data[SEC_W-1:0];
                default: ;
            endcase
        end
    end

    // Debounce the key sample
    always_comb
    begin
        debounce_shift_next = {debounce_shift_reg[DEB_W-2:0], key_sample};
        if (debounce_shift_next == '1)
            key_level_next = 1'b1;
        else if (debounce_shift_next == '0)
            key_level_next = 1'b0;
        else
            key_level_next = key_level_reg;
    end

    // Count ticks and advance the time once per second
    always_comb
    begin
        tick_inc          = tick_count_reg + TICK_W'(1);
        sec_tick          = run_flag_reg && (tick_inc >= tps_reg);
        tick_count_next   = tick_count_reg;
        second_count_next = second_count_reg;
        minute_count_next = minute_count_reg;
        hour_count_next   = hour_count_reg;
        alarm_latch_next  = alarm_latch_reg;
        if (run_flag_reg)
            tick_count_next = sec_tick ? '0 : tick_inc;
        if (sec_tick)
        begin
            if (second_count_reg >= SEC_LAST)
            begin
                second_count_next = '0;
                if (minute_count_reg >= MIN_LAST)
                begin
                    minute_count_next = '0;
                    hour_count_next   = (hour_count_reg >= HOUR_LAST) ? '0
                                      : hour_count_reg + HOUR_W'(1);
                end
                else
                    minute_count_next = minute_count_reg + MIN_W'(1);
            end
            else
                second_count_next = second_count_reg + SEC_W'(1);
            if (hour_count_next == alarm_hour_reg && minute_count_next == alarm_min_reg
                && second_count_next == alarm_sec_reg)
                alarm_latch_next = 1'b1;
        end
    end

    // Toggle running on a debounced press
    assign press         = key_level_prev_reg && !key_level_next;
    assign run_flag_next = run_flag_reg ^ press;

    // Advance the scan position
    assign scan_index_next = (scan_index_reg == SCAN_W'(SCAN_DIGITS - 1)) ? '0
                           : scan_index_reg + SCAN_W'(1);

    // Pick the value shown at this scan position
    always_comb
    begin
        unique case (scan_index_reg)
            DIG_HOUR_TENS, DIG_HOUR_UNITS: digit_value = MIN_W'(hour_count_next);
            DIG_MIN_TENS, DIG_MIN_UNITS:   digit_value = minute_count_next;
            DIG_SEC_TENS, DIG_SEC_UNITS:   digit_value = second_count_next;
            default:                       digit_value = '0;
        endcase
        digit_is_tens = (scan_index_reg == DIG_HOUR_TENS) || (scan_index_reg == DIG_MIN_TENS)
                     || (scan_index_reg == DIG_SEC_TENS);
        digit_bcd     = bcd_split(digit_value);
    end

    // Assemble the result
    always_comb
    begin
        result_next.scan_digit = scan_index_reg;
        if (scan_index_reg == DIG_DASH_HM || scan_index_reg == DIG_DASH_MS)
            result_next.scan_segments = SEG_DASH;
        else if (digit_is_tens)
            result_next.scan_segments = seg_code({1'b0, digit_bcd.tens});
        else
            result_next.scan_segments = seg_code(digit_bcd.units);
        result_next.hours      = hour_count_next;
        result_next.minutes    = minute_count_next;
        result_next.seconds    = second_count_next;
        result_next.running    = run_flag_next;
        result_next.alarm_flag = alarm_latch_next;
    end

    // Update the clock state on each accepted tick
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            debounce_shift_reg <= '1;
            key_level_reg      <= 1'b1;
            key_level_prev_reg <= 1'b1;
            run_flag_reg       <= 1'b1;
            tick_count_reg     <= '0;
            second_count_reg   <= '0;
            minute_count_reg   <= '0;
            hour_count_reg     <= '0;
            alarm_latch_reg    <= 1'b0;
            scan_index_reg     <= '0;
        end
        else if (in_fire)
        begin
            debounce_shift_reg <= debounce_shift_next;
            key_level_reg      <= key_level_next;
            key_level_prev_reg <= key_level_next;
            run_flag_reg       <= run_flag_next;
            tick_count_reg     <= tick_count_next;
            second_count_reg   <= second_count_next;
            minute_count_reg   <= minute_count_next;
            hour_count_reg     <= hour_count_next;
            alarm_latch_reg    <= alarm_latch_next;
            scan_index_reg     <= scan_index_next;
        end
    end

    // Hold results in the output and skid registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else if (in_fire)
        begin
            if (out_valid_reg && !out_fire)
                skid_valid_reg <= 1'b1;
            else
                out_valid_reg <= 1'b1;
        end
        else if (out_fire)
        begin
            if (skid_valid_reg)
                skid_valid_reg <= 1'b0;
            else
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            if (out_valid_reg && !out_fire)
                skid_reg <= result_next;
            else
                out_reg <= result_next;
        end
        else if (out_fire && skid_valid_reg)
            out_reg <= skid_reg;
    end

    assign out_valid     = out_valid_reg;
    assign scan_digit    = out_reg.scan_digit;
    assign scan_segments = out_reg.scan_segments;
    assign hours         = out_reg.hours;
    assign minutes       = out_reg.minutes;
    assign seconds       = out_reg.seconds;
    assign running       = out_reg.running;
    assign alarm_flag    = out_reg.alarm_flag;

endmodule

[design/dcpk_checker.sv]
// Port-level checker for the digital clock with pause key, bound to the top level.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module dcpk_checker
    import dcpk_pkg::*;
(
    input logic              clk,
    input logic              rst_n,
    input logic              out_valid,
    input logic              out_stall,
    input logic [SCAN_W-1:0] scan_digit,
    input logic [HOUR_W-1:0] hours,
    input logic [MIN_W-1:0]  minutes,
    input logic [SEC_W-1:0]  seconds,
    input logic              alarm_flag
);

    logic              seen_reg;
    logic              alarm_seen_reg;
    logic [SCAN_W-1:0] last_digit_reg;

    // Track the last delivered digit and whether the alarm was reported
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            seen_reg       <= 1'b0;
            alarm_seen_reg <= 1'b0;
            last_digit_reg <= '0;
        end
        else if (out_valid && !out_stall)
        begin
            seen_reg       <= 1'b1;
            alarm_seen_reg <= alarm_seen_reg || alarm_flag;
            last_digit_reg <= scan_digit;
        end
    end

    `CHK_ASSERT_NEXT(a_out_hold, out_valid && out_stall,
        out_valid && $stable(scan_digit) && $stable(seconds), "stalled request changed")
    `CHK_ASSERT(a_scan_order, !(out_valid && seen_reg) ||
        scan_digit == last_digit_reg + SCAN_W'(1), "scan digit out of sequence")
    `CHK_ASSERT(a_alarm_sticky, !(out_valid && alarm_seen_reg) || alarm_flag,
        "alarm flag dropped")
    `CHK_ASSERT(a_time_range, !out_valid ||
        (hours <= HOUR_LAST && minutes <= MIN_LAST && seconds <= SEC_LAST),
        "time out of range")

endmodule

bind digital_clock_with_pause_key_unit dcpk_checker u_dcpk_checker (.*);
